// ===== hw/rtl/sfc_pkg.sv =====
// Shared types, mode table and divider constants for the frame timing calculator.
// No dependencies; used by sfc_cfg_regs and sensor_frame_timing_calc.
`timescale 1ns / 1ps

package sfc_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_RATE  = 3'd1,
    ST_ABOVE_MAX = 3'd2,
    ST_NO_CLOCK  = 3'd3,
    ST_CORE_OOR  = 3'd4,
    ST_FRAME_OOR = 3'd5
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MASTER_CLK   = 2'd0;
  localparam logic [1:0] CFG_READOUT_MODE = 2'd1;
  localparam logic [1:0] CFG_DATA_ITF     = 2'd2;

  // Readout modes; the last code has no meaning
  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_QVGA  = 2'd1;
  localparam logic [1:0] MODE_QQVGA = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Pixel data interfaces; the last code has no divider
  localparam logic [1:0] ITF_8BIT = 2'd0;
  localparam logic [1:0] ITF_4BIT = 2'd1;
  localparam logic [1:0] ITF_1BIT = 2'd2;
  localparam logic [1:0] ITF_NONE = 2'd3;

  typedef struct packed {
    logic [31:0] master_clock_hz;
    logic [1:0]  readout_mode;
    logic [1:0]  data_interface;
  } cfg_t;

  // Core clock limit and derived widths
  localparam int unsigned CORE_MAX_HZ = 6000000;
  localparam int CORE_W = $clog2(CORE_MAX_HZ + 1);

  // Mode table
  localparam logic [15:0] LINE_LONG  = 16'h0178;
  localparam logic [15:0] LINE_SHORT = 16'h00D7;
  localparam logic [15:0] MIN_FULL   = 16'h0158;
  localparam logic [15:0] MIN_QVGA   = 16'h0104;
  localparam logic [15:0] MIN_QQVGA  = 16'h0080;
  localparam logic [7:0]  MAX_FULL   = 8'd45;
  localparam logic [7:0]  MAX_QVGA   = 8'd60;
  localparam logic [7:0]  MAX_QQVGA  = 8'd120;

  // Listed frame rates and their codes
  localparam logic [7:0] FPS_15  = 8'd15;
  localparam logic [7:0] FPS_20  = 8'd20;
  localparam logic [7:0] FPS_30  = 8'd30;
  localparam logic [7:0] FPS_45  = 8'd45;
  localparam logic [7:0] FPS_60  = 8'd60;
  localparam logic [7:0] FPS_120 = 8'd120;

  localparam logic [2:0] FC_15  = 3'd0;
  localparam logic [2:0] FC_20  = 3'd1;
  localparam logic [2:0] FC_30  = 3'd2;
  localparam logic [2:0] FC_45  = 3'd3;
  localparam logic [2:0] FC_60  = 3'd4;
  localparam logic [2:0] FC_120 = 3'd5;

  // Denominators line * fps for every line/rate pair
  localparam longint unsigned DEN_L15  = 64'(LINE_LONG) * 15;
  localparam longint unsigned DEN_L20  = 64'(LINE_LONG) * 20;
  localparam longint unsigned DEN_L30  = 64'(LINE_LONG) * 30;
  localparam longint unsigned DEN_L45  = 64'(LINE_LONG) * 45;
  localparam longint unsigned DEN_L60  = 64'(LINE_LONG) * 60;
  localparam longint unsigned DEN_L120 = 64'(LINE_LONG) * 120;
  localparam longint unsigned DEN_S15  = 64'(LINE_SHORT) * 15;
  localparam longint unsigned DEN_S20  = 64'(LINE_SHORT) * 20;
  localparam longint unsigned DEN_S30  = 64'(LINE_SHORT) * 30;
  localparam longint unsigned DEN_S45  = 64'(LINE_SHORT) * 45;
  localparam longint unsigned DEN_S60  = 64'(LINE_SHORT) * 60;
  localparam longint unsigned DEN_S120 = 64'(LINE_SHORT) * 120;
  localparam longint unsigned DEN_MIN  = DEN_S15;

  // Reciprocals floor(2^32 / den); the estimate is then at most one low
  localparam int RCP_SHIFT = 32;
  localparam longint unsigned RCP_ONE = 64'd1 << RCP_SHIFT;
  localparam int RCP_W = $clog2(RCP_ONE / DEN_MIN + 1);
  localparam int Q_W   = $clog2(CORE_MAX_HZ / DEN_MIN + 2);
  localparam int REM_W = $clog2(2 * DEN_L120);
  localparam int FL_W  = Q_W + 2;
  localparam int P3_W  = Q_W + 16;

  localparam logic [RCP_W-1:0] RCP_L15  = RCP_W'(RCP_ONE / DEN_L15);
  localparam logic [RCP_W-1:0] RCP_L20  = RCP_W'(RCP_ONE / DEN_L20);
  localparam logic [RCP_W-1:0] RCP_L30  = RCP_W'(RCP_ONE / DEN_L30);
  localparam logic [RCP_W-1:0] RCP_L45  = RCP_W'(RCP_ONE / DEN_L45);
  localparam logic [RCP_W-1:0] RCP_L60  = RCP_W'(RCP_ONE / DEN_L60);
  localparam logic [RCP_W-1:0] RCP_L120 = RCP_W'(RCP_ONE / DEN_L120);
  localparam logic [RCP_W-1:0] RCP_S15  = RCP_W'(RCP_ONE / DEN_S15);
  localparam logic [RCP_W-1:0] RCP_S20  = RCP_W'(RCP_ONE / DEN_S20);
  localparam logic [RCP_W-1:0] RCP_S30  = RCP_W'(RCP_ONE / DEN_S30);
  localparam logic [RCP_W-1:0] RCP_S45  = RCP_W'(RCP_ONE / DEN_S45);
  localparam logic [RCP_W-1:0] RCP_S60  = RCP_W'(RCP_ONE / DEN_S60);
  localparam logic [RCP_W-1:0] RCP_S120 = RCP_W'(RCP_ONE / DEN_S120);

  typedef struct packed {
    logic       ok;
    logic [2:0] code;
  } fps_lookup_t;

  function automatic fps_lookup_t fps_lookup(input logic [7:0] fps);
    fps_lookup_t r;
    r.ok = 1'b1;
    unique case (fps)
      FPS_15:  r.code = FC_15;
      FPS_20:  r.code = FC_20;
      FPS_30:  r.code = FC_30;
      FPS_45:  r.code = FC_45;
      FPS_60:  r.code = FC_60;
      FPS_120: r.code = FC_120;
      default: begin
        r.ok   = 1'b0;
        r.code = FC_15;
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] mode_line(input logic [1:0] mode);
    unique case (mode)
      MODE_QQVGA: return LINE_SHORT;
      default:    return LINE_LONG;
    endcase
  endfunction

  function automatic logic [15:0] mode_min_frame(input logic [1:0] mode);
    unique case (mode)
      MODE_QVGA:  return MIN_QVGA;
      MODE_QQVGA: return MIN_QQVGA;
      default:    return MIN_FULL;
    endcase
  endfunction

  function automatic logic [7:0] mode_max_fps(input logic [1:0] mode);
    unique case (mode)
      MODE_QVGA:  return MAX_QVGA;
      MODE_QQVGA: return MAX_QQVGA;
      default:    return MAX_FULL;
    endcase
  endfunction

  function automatic logic [15:0] den_sel(input logic short_line, input logic [2:0] code);
    unique case ({short_line, code})
      {1'b0, FC_15}:  return 16'(DEN_L15);
      {1'b0, FC_20}:  return 16'(DEN_L20);
      {1'b0, FC_30}:  return 16'(DEN_L30);
      {1'b0, FC_45}:  return 16'(DEN_L45);
      {1'b0, FC_60}:  return 16'(DEN_L60);
      {1'b0, FC_120}: return 16'(DEN_L120);
      {1'b1, FC_15}:  return 16'(DEN_S15);
      {1'b1, FC_20}:  return 16'(DEN_S20);
      {1'b1, FC_30}:  return 16'(DEN_S30);
      {1'b1, FC_45}:  return 16'(DEN_S45);
      {1'b1, FC_60}:  return 16'(DEN_S60);
      {1'b1, FC_120}: return 16'(DEN_S120);
      default:        return 16'(DEN_L15);
    endcase
  endfunction

  function automatic logic [RCP_W-1:0] rcp_sel(input logic short_line,
                                               input logic [2:0] code);
    unique case ({short_line, code})
      {1'b0, FC_15}:  return RCP_L15;
      {1'b0, FC_20}:  return RCP_L20;
      {1'b0, FC_30}:  return RCP_L30;
      {1'b0, FC_45}:  return RCP_L45;
      {1'b0, FC_60}:  return RCP_L60;
      {1'b0, FC_120}: return RCP_L120;
      {1'b1, FC_15}:  return RCP_S15;
      {1'b1, FC_20}:  return RCP_S20;
      {1'b1, FC_30}:  return RCP_S30;
      {1'b1, FC_45}:  return RCP_S45;
      {1'b1, FC_60}:  return RCP_S60;
      {1'b1, FC_120}: return RCP_S120;
      default:        return RCP_L15;
    endcase
  endfunction

  // Pipeline stage contents
  typedef struct packed {
    status_t           status;
    logic [15:0]       line;
    logic [CORE_W-1:0] core;
    logic [15:0]       den;
    logic [RCP_W-1:0]  rcp;
    logic [15:0]       min_frame;
  } s1_t;

  typedef struct packed {
    status_t           status;
    logic [15:0]       line;
    logic [CORE_W-1:0] core;
    logic [15:0]       den;
    logic [15:0]       min_frame;
    logic [Q_W-1:0]    q0;
  } s2_t;

  typedef struct packed {
    status_t          status;
    logic [15:0]      line;
    logic [15:0]      den;
    logic [15:0]      min_frame;
    logic [Q_W-1:0]   q0;
    logic [REM_W-1:0] rem;
  } s3_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] line;
    logic [15:0] frame;
    logic [15:0] expo;
  } res_t;

endpackage

// ===== hw/rtl/sfc_cfg_regs.sv =====
// Configuration register file of the frame timing calculator.
// Depends on sfc_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module sfc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output sfc_pkg::cfg_t cfg
);

  sfc_pkg::cfg_t cfg_r;

  // Writes are always accepted
  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfc_pkg::CFG_MASTER_CLK:   cfg_r.master_clock_hz <= cfg_data;
        sfc_pkg::CFG_READOUT_MODE: cfg_r.readout_mode    <= cfg_data[1:0];
        sfc_pkg::CFG_DATA_ITF:     cfg_r.data_interface  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sensor_frame_timing_calc.sv =====
// Top level of the frame timing calculator: checks, reciprocal divider pipeline.
// Depends on sfc_pkg and sfc_cfg_regs.
`timescale 1ns / 1ps

// A request word carries a target frame rate; each one returns exactly one result
// word with a status code and the line length, frame length and maximum
// integration. The pipeline is four register stages deep (checks and core clock,
// reciprocal multiply, remainder, correction and range check), and a new request
// is taken every cycle unless the pipeline is full and the output is stalled.
// The frame length division is a multiply by a constant reciprocal selected
// from the line/rate pair, followed by one correction step. Configuration writes
// are always accepted and must only be issued while no request is in flight.
module sensor_frame_timing_calc (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_target_fps,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_line_length,
  output logic [15:0] out_frame_length,
  output logic [15:0] out_max_exposure,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  sfc_pkg::cfg_t cfg;

  sfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  sfc_pkg::s1_t  s1_r, s1_nxt;
  sfc_pkg::s2_t  s2_r, s2_nxt;
  sfc_pkg::s3_t  s3_r, s3_nxt;
  sfc_pkg::res_t out_r, out_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  // Per-stage advance: a stage moves when empty or when the next one moves
  assign rdy4 = !out_v_r || !out_stall;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_stall = !rdy1;

  // Stage 1: argument checks and core clock
  sfc_pkg::fps_lookup_t fl_lu;
  logic        mode_ok;
  logic [30:0] core_full;

  always_comb begin
    fl_lu   = sfc_pkg::fps_lookup(in_target_fps);
    mode_ok = (cfg.readout_mode != sfc_pkg::MODE_NONE);
    core_full = (cfg.data_interface == sfc_pkg::ITF_1BIT) ?
                31'(cfg.master_clock_hz >> 3) : 31'(cfg.master_clock_hz >> 1);

    s1_nxt.line      = mode_ok ? sfc_pkg::mode_line(cfg.readout_mode) : 16'd0;
    s1_nxt.core      = core_full[sfc_pkg::CORE_W-1:0];
    s1_nxt.min_frame = sfc_pkg::mode_min_frame(cfg.readout_mode);
    s1_nxt.den       = sfc_pkg::den_sel(cfg.readout_mode == sfc_pkg::MODE_QQVGA,
                                        fl_lu.code);
    s1_nxt.rcp       = sfc_pkg::rcp_sel(cfg.readout_mode == sfc_pkg::MODE_QQVGA,
                                        fl_lu.code);

    priority if (!fl_lu.ok || !mode_ok) begin
      s1_nxt.status = sfc_pkg::ST_BAD_RATE;
    end else if (in_target_fps > sfc_pkg::mode_max_fps(cfg.readout_mode)) begin
      s1_nxt.status = sfc_pkg::ST_ABOVE_MAX;
    end else if (cfg.data_interface == sfc_pkg::ITF_NONE ||
                 cfg.master_clock_hz == 32'd0) begin
      s1_nxt.status = sfc_pkg::ST_NO_CLOCK;
    end else if (core_full == 31'd0 || core_full > 31'(sfc_pkg::CORE_MAX_HZ)) begin
      s1_nxt.status = sfc_pkg::ST_CORE_OOR;
    end else begin
      s1_nxt.status = sfc_pkg::ST_OK;
    end
  end

  // Stage 2: quotient estimate core * (2^32 / den) >> 32
  logic [sfc_pkg::CORE_W+sfc_pkg::RCP_W-1:0] prod2;

  always_comb begin
    prod2 = (sfc_pkg::CORE_W+sfc_pkg::RCP_W)'(s1_r.core) *
            (sfc_pkg::CORE_W+sfc_pkg::RCP_W)'(s1_r.rcp);
    s2_nxt.status    = s1_r.status;
    s2_nxt.line      = s1_r.line;
    s2_nxt.core      = s1_r.core;
    s2_nxt.den       = s1_r.den;
    s2_nxt.min_frame = s1_r.min_frame;
    s2_nxt.q0        = sfc_pkg::Q_W'(prod2 >> sfc_pkg::RCP_SHIFT);
  end

  // Stage 3: remainder core - q0 * den, below twice den
  logic [sfc_pkg::P3_W-1:0] prod3;
  logic [sfc_pkg::P3_W-1:0] diff3;

  always_comb begin
    prod3 = sfc_pkg::P3_W'(s2_r.q0) * sfc_pkg::P3_W'(s2_r.den);
    diff3 = sfc_pkg::P3_W'(s2_r.core) - prod3;
    s3_nxt.status    = s2_r.status;
    s3_nxt.line      = s2_r.line;
    s3_nxt.den       = s2_r.den;
    s3_nxt.min_frame = s2_r.min_frame;
    s3_nxt.q0        = s2_r.q0;
    s3_nxt.rem       = diff3[sfc_pkg::REM_W-1:0];
  end

  // Stage 4: correct the estimate, round up, range check
  logic                   ge;
  logic                   up;
  logic [sfc_pkg::FL_W-1:0] fl;

  always_comb begin
    ge = (s3_r.rem >= sfc_pkg::REM_W'(s3_r.den));
    up = ge ? (s3_r.rem != sfc_pkg::REM_W'(s3_r.den)) : (s3_r.rem != '0);
    fl = sfc_pkg::FL_W'(s3_r.q0) + sfc_pkg::FL_W'(ge) + sfc_pkg::FL_W'(up);

    out_nxt.line  = s3_r.line;
    out_nxt.frame = 16'd0;
    out_nxt.expo  = 16'd0;
    priority if (s3_r.status != sfc_pkg::ST_OK) begin
      out_nxt.status = s3_r.status;
    end else if (32'(fl) < 32'(s3_r.min_frame) || 32'(fl) > 32'hFFFF) begin
      out_nxt.status = sfc_pkg::ST_FRAME_OOR;
    end else begin
      out_nxt.status = sfc_pkg::ST_OK;
      out_nxt.frame  = 16'(fl);
      out_nxt.expo   = 16'(fl) - 16'd2;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r  <= in_valid;
      if (rdy2) s2_v_r  <= s1_v_r;
      if (rdy3) s3_v_r  <= s2_v_r;
      if (rdy4) out_v_r <= s3_v_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r  <= s1_nxt;
    if (rdy2 && s1_v_r)   s2_r  <= s2_nxt;
    if (rdy3 && s2_v_r)   s3_r  <= s3_nxt;
    if (rdy4 && s3_v_r)   out_r <= out_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_status       = out_r.status;
  assign out_line_length  = out_r.line;
  assign out_frame_length = out_r.frame;
  assign out_max_exposure = out_r.expo;

  // A good result carries consistent timing words
  a_ok_expo: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status == sfc_pkg::ST_OK |->
      out_r.expo == out_r.frame - 16'd2 && out_r.frame >= sfc_pkg::MIN_QQVGA)
    else $error("good result with inconsistent frame/exposure");

  // A failed result has zero frame and exposure
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status != sfc_pkg::ST_OK |->
      out_r.frame == 16'd0 && out_r.expo == 16'd0)
    else $error("failed result with nonzero timing");

  // Input is only held off when the pipeline is full back to the output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && s2_v_r && s3_v_r && out_v_r && out_stall)
    else $error("input stalled with room in pipeline");

  // A stalled output word is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r && $stable(out_r))
    else $error("stalled result changed");

endmodule
